// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define DTT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define DTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/dtt_pkg.sv =====
`timescale 1ns / 1ps
package dtt_pkg;

  localparam int TIMERS = 16;
  localparam int POS_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W  = $clog2(TIMERS + 1);
  localparam int ID_W   = 4;
  localparam int FUNC_W = 3;
  localparam int ST_W   = 3;
  localparam int TW     = 64;
  localparam int CW     = 32;

  localparam logic [CW-1:0] WINDOW_RST = CW'(60 * 60 * 1000);

  localparam logic [FUNC_W-1:0] F_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] F_CANCEL  = 3'd1;
  localparam logic [FUNC_W-1:0] F_RESET   = 3'd2;
  localparam logic [FUNC_W-1:0] F_RESTART = 3'd3;
  localparam logic [FUNC_W-1:0] F_EXPIRE  = 3'd4;
  localparam logic [FUNC_W-1:0] F_QUERY   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOTARMED = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_EXPIRED  = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd4;

  typedef struct packed {
    logic          armed;
    logic          rpt;
    logic          due;
    logic [TW-1:0] deadline;
    logic [TW-1:0] period;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_CALC,
    S_APPLY,
    S_SELECT,
    S_OUT
  } state_t;

endpackage

// ===== sv/dtt_cell.sv =====
`timescale 1ns / 1ps
module dtt_cell import dtt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  entry_t din,
  output entry_t dout
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.armed <= 1'b0;
      ent_r.rpt   <= 1'b0;
      ent_r.due   <= 1'b0;
    end else if (shift) begin
      ent_r <= din;
    end
  end

  assign dout = ent_r;

endmodule

// ===== sv/deadline_timer_table_unit.sv =====
`timescale 1ns / 1ps
// Timer table with TIMERS slots held in a ring of cells that rotates one slot
// per cycle while a pass runs, past a single head unit; every pass leaves
// the ring aligned, so the head sees slot k while pos_r equals k.
// Input channel in_*: one item per operation, accepted when in_valid is high
// and in_stall low. in_stall stays high until the block is idle again.
// Output channel out_*: results held in a register until out_stall is low;
// out_last marks the final result of an item.
// Sequence: every item takes a gather pass and a calc state; add and reset
// that write a slot then take an apply pass. Expire with n due timers emits
// n results, each after a further select pass, plus one closing pass; a stalled
// receiver simply holds the block in its output state.
// Throughput: one item at a time; the next item is taken the cycle after the
// last result leaves (after the closing pass for an expire that emitted).
// cfg_wr_en writes rollback_window_ms; write it only while idle.
// Synchronous reset empties the table, zeroes the last seen time and loads
// the default window of one hour; the block is ready the cycle after.
module deadline_timer_table_unit import dtt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [TW-1:0]     in_now_ms,
  input  logic [TW-1:0]     in_interval_ms,
  input  logic              in_cyclic,
  input  logic              in_from_now,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ID_W-1:0]   out_timer_id_res,
  output logic [ST_W-1:0]   out_status,
  output logic [TW-1:0]     out_remaining_ms,
  output logic              out_new_earliest,
  output logic              out_last,
  input  logic              cfg_wr_en,
  input  logic [CW-1:0]     cfg_wr_data
);

  `include "assert_macros.svh"

  localparam int CW2 = ID_W + POS_W + 1;

  state_t state_r, state_nxt, after_out_r;

  entry_t ring [TIMERS];
  entry_t head, head_mod;
  logic   shift;

  logic [POS_W-1:0]  pos_r, tgt_r, free_id_r, best_id_r, pend_id_r;
  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   id_r;
  logic [TW-1:0]     now_r, ival_r, lst_r, start_r, newd_r, tgt_period_r, best_d_r;
  logic [CW-1:0]     window_r;
  logic              cyc_r, fromnow_r, roll_r, free_found_r, tgt_armed_r, any_r;
  logic              best_v_r, pend_v_r, blocked_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [ID_W-1:0]   o_id_r;
  logic [ST_W-1:0]   o_st_r;
  logic [TW-1:0]     o_rem_r;
  logic              o_first_r, o_last_r;

  logic pos_last, in_acc, valid_id, hit, is_pend, calc_apply, calc_select;

  // ring of cells
  for (genvar i = 0; i < TIMERS; i++) begin : g_ring
    entry_t din;
    if (i == TIMERS - 1) begin : g_tail
      assign din = head_mod;
    end else begin : g_mid
      assign din = ring[i+1];
    end
    dtt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .din   (din),
      .dout  (ring[i])
    );
  end

  assign head     = ring[0];
  assign pos_last = (pos_r == POS_W'(TIMERS - 1));
  assign in_acc   = in_valid && !in_stall;
  assign valid_id = CW2'(id_r) < CW2'(TIMERS);
  assign hit      = valid_id && (CW2'(pos_r) == CW2'(id_r));
  assign is_pend  = pend_v_r && (pos_r == pend_id_r);

  assign calc_apply = (func_r == F_ADD && free_found_r) ||
                      (func_r == F_RESET && valid_id &&
                       !(ival_r == tgt_period_r && !fromnow_r) && tgt_armed_r);
  assign calc_select = (func_r == F_EXPIRE) && any_r && (cnt_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_GATHER;
      S_GATHER: if (pos_last) state_nxt = S_CALC;
      S_CALC: begin
        if (calc_apply) state_nxt = S_APPLY;
        else if (calc_select) state_nxt = S_SELECT;
        else state_nxt = S_OUT;
      end
      S_APPLY:  if (pos_last) state_nxt = S_OUT;
      S_SELECT: if (pos_last) state_nxt = (cnt_r != '0) ? S_OUT : S_IDLE;
      S_OUT:    if (!out_stall) state_nxt = after_out_r;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    shift     = 1'b0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE:   in_stall = 1'b0;
      S_GATHER: shift = 1'b1;
      S_APPLY:  shift = 1'b1;
      S_SELECT: shift = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  // head unit: what the head slot turns into as it moves to the tail
  always_comb begin
    head_mod = head;
    case (state_r)
      S_GATHER: begin
        if (hit && head.armed && func_r == F_CANCEL) head_mod.armed = 1'b0;
        if (hit && head.armed && func_r == F_RESTART)
          head_mod.deadline = now_r + head.period;
        if (func_r == F_EXPIRE)
          head_mod.due = head.armed && (roll_r || head.deadline <= now_r);
      end
      S_APPLY: begin
        if (pos_r == tgt_r) begin
          head_mod.armed    = 1'b1;
          head_mod.deadline = newd_r;
          head_mod.period   = ival_r;
          if (func_r == F_ADD) head_mod.rpt = cyc_r;
        end
      end
      S_SELECT: begin
        if (is_pend) begin
          head_mod.due = 1'b0;
          if (head.rpt) head_mod.deadline = now_r + head.period;
          else head_mod.armed = 1'b0;
        end
      end
      default: head_mod = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      lst_r       <= '0;
      window_r    <= WINDOW_RST;
      pend_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) window_r <= cfg_wr_data;
      if (shift) pos_r <= pos_last ? '0 : pos_r + 1'b1;
      if (state_r == S_CALC && func_r == F_EXPIRE && any_r) lst_r <= now_r;
      if (state_r == S_CALC) pend_v_r <= 1'b0;
      if (in_acc) best_v_r <= 1'b0;
      if (state_r == S_CALC && calc_select) best_v_r <= 1'b0;
      if (state_r == S_GATHER && func_r == F_QUERY && head.armed &&
          (!best_v_r || head.deadline < best_d_r))
        best_v_r <= 1'b1;
      if (state_r == S_SELECT) begin
        if (pos_last) begin
          best_v_r <= 1'b0;
          if (cnt_r != '0) pend_v_r <= 1'b1;
        end else if (head.due && !is_pend && (!best_v_r || head.deadline < best_d_r)) begin
          best_v_r <= 1'b1;
        end
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r       <= in_func;
      id_r         <= in_timer_id;
      now_r        <= in_now_ms;
      ival_r       <= in_interval_ms;
      cyc_r        <= in_cyclic;
      fromnow_r    <= in_from_now;
      roll_r       <= (in_now_ms < lst_r) && ((lst_r - in_now_ms) > TW'(window_r));
      free_found_r <= 1'b0;
      tgt_armed_r  <= 1'b0;
      any_r        <= 1'b0;
      cnt_r        <= '0;
    end
    case (state_r)
      S_GATHER: begin
        if (!head.armed && !free_found_r) begin
          free_found_r <= 1'b1;
          free_id_r    <= pos_r;
        end
        if (head.armed) any_r <= 1'b1;
        if (hit) begin
          tgt_armed_r  <= head.armed;
          tgt_period_r <= head.period;
          start_r      <= fromnow_r ? now_r : head.deadline - head.period;
        end
        if (func_r == F_EXPIRE && head_mod.due) cnt_r <= cnt_r + 1'b1;
        if (func_r == F_QUERY && head.armed && (!best_v_r || head.deadline < best_d_r)) begin
          best_d_r  <= head.deadline;
          best_id_r <= pos_r;
        end
      end
      S_CALC: begin
        blocked_r   <= 1'b0;
        newd_r      <= ((func_r == F_ADD) ? now_r : start_r) + ival_r;
        tgt_r       <= (func_r == F_ADD) ? free_id_r : POS_W'(id_r);
        after_out_r <= S_IDLE;
        o_id_r      <= '0;
        if (func_r != F_QUERY) o_rem_r <= '0;
        o_first_r   <= 1'b0;
        o_last_r    <= 1'b1;
        case (func_r)
          F_ADD:     o_st_r <= ST_FULL;
          F_CANCEL:  o_st_r <= (valid_id && tgt_armed_r) ? ST_OK : ST_NOTARMED;
          F_RESET: begin
            if (!valid_id) o_st_r <= ST_NOTARMED;
            else if (ival_r == tgt_period_r && !fromnow_r) o_st_r <= ST_OK;
            else o_st_r <= ST_NOTARMED;
          end
          F_RESTART: o_st_r <= (valid_id && tgt_armed_r) ? ST_OK : ST_NOTARMED;
          F_EXPIRE:  o_st_r <= ST_NONE;
          F_QUERY: begin
            o_st_r <= ST_OK;
            if (!best_v_r) o_rem_r <= '1;
            else if (now_r >= best_d_r) o_rem_r <= '0;
            else o_rem_r <= best_d_r - now_r;
          end
          default:   o_st_r <= ST_NOTARMED;
        endcase
      end
      S_APPLY: begin
        if (pos_r != tgt_r && head.armed &&
            (head.deadline < newd_r || (head.deadline == newd_r && pos_r < tgt_r)))
          blocked_r <= 1'b1;
        if (pos_last) begin
          o_id_r      <= (func_r == F_ADD) ? ID_W'(tgt_r) : '0;
          o_st_r      <= ST_OK;
          o_rem_r     <= '0;
          o_last_r    <= 1'b1;
          after_out_r <= S_IDLE;
          o_first_r   <= !(blocked_r || (pos_r != tgt_r && head.armed &&
                         (head.deadline < newd_r ||
                          (head.deadline == newd_r && pos_r < tgt_r))));
        end
      end
      S_SELECT: begin
        if (head.due && !is_pend && (!best_v_r || head.deadline < best_d_r)) begin
          best_d_r  <= head.deadline;
          best_id_r <= pos_r;
        end
        if (pos_last && cnt_r != '0) begin
          if (head.due && !is_pend && (!best_v_r || head.deadline < best_d_r)) begin
            o_id_r    <= ID_W'(pos_r);
            pend_id_r <= pos_r;
          end else begin
            o_id_r    <= ID_W'(best_id_r);
            pend_id_r <= best_id_r;
          end
          o_st_r      <= ST_EXPIRED;
          o_rem_r     <= '0;
          o_first_r   <= 1'b0;
          o_last_r    <= (cnt_r == CNT_W'(1));
          cnt_r       <= cnt_r - 1'b1;
          after_out_r <= S_SELECT;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_timer_id_res = o_id_r;
  assign out_status       = o_st_r;
  assign out_remaining_ms = o_rem_r;
  assign out_new_earliest = o_first_r;
  assign out_last         = o_last_r;

  // ring must be aligned (head at slot 0) whenever no pass runs
  `DTT_ASSERT(a_ring_aligned,
    !(state_r == S_IDLE || state_r == S_CALC || state_r == S_OUT) || pos_r == '0)
  `DTT_ASSERT_NEXT(a_accept_starts_scan, in_valid && !in_stall,
    state_r == S_GATHER && pos_r == '0)
  `DTT_ASSERT(a_cnt_bound, state_r == S_IDLE || cnt_r <= CNT_W'(TIMERS))
  `DTT_ASSERT_NEXT(a_expired_last_ends, out_valid && !out_stall &&
    out_status == ST_EXPIRED && out_last, cnt_r == '0)

endmodule
